// ----- rtl/cgp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgp_pkg
// shared types, stage map and saturating helpers for the conservative to
// primitive gradient pipeline
// ----------------------------------------------------------------------------
package cgp_pkg;

	// register map of the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_M1 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CV   = 2'd1;
	localparam logic [30:0] GAMMA_M1_RST = 31'd26214;
	localparam logic [30:0] INV_CV_RST   = 31'd26214;

	// magnitude of an intermediate never exceeds 2^62-1
	localparam int MAG_W = 62;
	localparam int QUO_W = 48;
	localparam int MUL_A_W = 48;
	localparam logic signed [63:0] LIM_P = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] LIM_N = -64'sh3FFF_FFFF_FFFF_FFFF;

	// latencies of the arithmetic units
	localparam int DIV_LAT = QUO_W;
	localparam int MUL_LAT = 3;

	// stage map of the top level
	localparam int ST_MUL1 = 1 + DIV_LAT;
	localparam int ST_SUB1 = ST_MUL1 + MUL_LAT;
	localparam int ST_ABS1 = ST_SUB1 + 1;
	localparam int ST_MUL2 = ST_ABS1 + 1;
	localparam int ST_SUB2 = ST_MUL2 + MUL_LAT;
	localparam int ST_SUB3 = ST_SUB2 + 1;
	localparam int ST_MULG = ST_SUB3 + 1;
	localparam int ST_DIVT = ST_MULG + 1;
	localparam int ST_PS   = ST_MULG + MUL_LAT;
	localparam int ST_VS   = ST_MUL2 + DIV_LAT;
	localparam int ST_MULC = ST_DIVT + DIV_LAT;
	localparam int ST_FIN  = ST_MULC + MUL_LAT;
	localparam int N_STG   = ST_FIN;

	typedef struct packed {
		logic signed [31:0] density;
		logic signed [31:0] momentum;
		logic signed [31:0] total_energy;
		logic signed [31:0] density_slope;
		logic signed [31:0] momentum_slope;
		logic signed [31:0] energy_slope;
		logic               last_point;
	} cgp_in_t;

	typedef struct packed {
		logic signed [31:0] pressure_slope;
		logic signed [31:0] velocity_slope;
		logic signed [31:0] temperature_slope;
		logic               bad_density;
		logic               last_out;
	} cgp_out_t;

	// one step of the restoring divider
	typedef struct packed {
		logic             sat;
		logic [30:0]      dvs;
		logic [30:0]      rem;
		logic [QUO_W-1:0] bits;
		logic [QUO_W-1:0] quo;
	} div_stage_t;

	// side data that travels with a request through the pipeline
	typedef struct packed {
		logic               last;
		logic               bad;
		logic [30:0]        rho;
		logic [31:0]        drho_mag;
		logic               drho_neg;
		logic               m_neg;
		logic               en_neg;
		logic               a_neg;
		logic               p1_neg;
		logic               q_neg;
		logic               ts_neg;
		logic signed [31:0] dm;
		logic signed [31:0] de;
		logic signed [31:0] ps;
		logic signed [31:0] vs;
	} cgp_ctx_t;

	function automatic logic signed [63:0] clamp_lim(logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > LIM_P) r = LIM_P;
		if (v < LIM_N) r = LIM_N;
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] mag62(logic signed [63:0] v);
		logic [63:0] n;
		n = -v;
		return v[63] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	function automatic logic signed [63:0] apply_sign(logic [MAG_W-1:0] m, logic neg);
		logic signed [63:0] p;
		p = {2'b00, m};
		return neg ? -p : p;
	endfunction

	function automatic logic [31:0] mag32(logic signed [31:0] v);
		logic [31:0] n;
		n = -v;
		return v[31] ? n : v;
	endfunction

	function automatic logic signed [31:0] sat32(logic [MAG_W-1:0] m, logic neg);
		logic [31:0] n;
		n = -m[31:0];
		if (neg) return (m >= 62'h8000_0000) ? 32'sh8000_0000 : n;
		return (m >= 62'h7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
	endfunction

endpackage

// ----- rtl/conservative_gradient_to_primitive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conservative_gradient_to_primitive
// 1d euler point: conserved state and its slopes in, pressure, velocity and
// temperature slopes out, signed q16.16 with saturation
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// request   in         start high, busy low  in_item (cgp_in_t)
// result    out        done strobe, 1 cycle  result (cgp_out_t)
// config    in         wr_en                 wr_index, wr_data
//
// one request is taken every cycle; busy never rises
// results leave in the order of their requests; the latency is set by two
// 48-stage bit-per-stage dividers in series, each followed by a three stage
// multiplier
// reset clears the valid bits and the two registers to their defaults
// the receiver cannot stall, so nothing inside ever holds
//
module conservative_gradient_to_primitive import cgp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cgp_in_t              in_item,
	output logic                 done,
	output cgp_out_t             result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [30:0]          wr_data
);

	// configuration registers
	logic [30:0] gamma_m1_q;
	logic [30:0] inv_cv_q;

	// side data pipeline, valid bits travel alongside
	cgp_ctx_t ctx_s [1:N_STG];
	cgp_ctx_t ctx_nxt [1:N_STG-1];
	logic     vld_s [1:N_STG];
	cgp_ctx_t ctx_in;

	// divider operands at stage 1
	logic [31:0] m_mag_s1;
	logic [31:0] en_mag_s1;

	// unit results
	logic [QUO_W-1:0] u_q;
	logic [QUO_W-1:0] e_q;
	logic [QUO_W-1:0] vs_q;
	logic [QUO_W-1:0] ts_q;
	logic [MAG_W-1:0] t1_p;
	logic [MAG_W-1:0] t3_p;
	logic [MAG_W-1:0] t2_p;
	logic [MAG_W-1:0] p2_p;
	logic [MAG_W-1:0] ps_p;
	logic [MAG_W-1:0] tc_p;

	// short delay lines for velocity magnitude and energy term
	logic [QUO_W-1:0]   um_s [ST_MUL1+1:ST_MUL2];
	logic signed [63:0] t3_s [ST_SUB1+1:ST_SUB3];

	// arithmetic pipeline registers
	logic signed [63:0] a_s53;
	logic signed [63:0] p1_s53;
	logic [MAG_W-1:0]   a_mag_s54;
	logic [MAG_W-1:0]   p1_mag_s54;
	logic signed [63:0] ts0_s58;
	logic signed [63:0] qv_s58;
	logic signed [63:0] ts1_s59;
	logic [MAG_W-1:0]   q_mag_s59;
	logic [MAG_W-1:0]   ts1_mag_s60;

	// combinational stage values
	logic signed [63:0] t1s;
	logic signed [63:0] hs;
	logic signed [63:0] t3s;
	logic signed [63:0] t2s;
	logic signed [63:0] p2s;
	logic signed [63:0] dm64;
	logic signed [63:0] de64;

	// output registers
	logic     done_q;
	cgp_out_t res_q;

	assign busy = 1'b0;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_m1_q <= GAMMA_M1_RST;
			inv_cv_q <= INV_CV_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_GAMMA_M1: gamma_m1_q <= wr_data;
				CFG_INV_CV:   inv_cv_q <= wr_data;
				default:      ;
			endcase
		end
	end

	// ---------------- stage 1: capture ----------------
	always_comb begin
		ctx_in = '0;
		ctx_in.last = in_item.last_point;
		ctx_in.bad = in_item.density[31] || (in_item.density == 32'sd0);
		ctx_in.rho = in_item.density[30:0];
		ctx_in.drho_mag = mag32(in_item.density_slope);
		ctx_in.drho_neg = in_item.density_slope[31];
		ctx_in.m_neg = in_item.momentum[31];
		ctx_in.en_neg = in_item.total_energy[31];
		ctx_in.dm = in_item.momentum_slope;
		ctx_in.de = in_item.energy_slope;
	end

	always_ff @(posedge clk) begin
		m_mag_s1 <= mag32(in_item.momentum);
		en_mag_s1 <= mag32(in_item.total_energy);
	end

	// u = m / rho and e = E / rho
	cgp_div u_div (
		.clk      (clk),
		.dividend ({30'd0, m_mag_s1}),
		.divisor  (ctx_s[1].rho),
		.quotient (u_q)
	);

	cgp_div e_div (
		.clk      (clk),
		.dividend ({30'd0, en_mag_s1}),
		.divisor  (ctx_s[1].rho),
		.quotient (e_q)
	);

	// u * drho and e * drho
	cgp_mul t1_mul (
		.clk     (clk),
		.mul_a   (u_q),
		.mul_b   ({30'd0, ctx_s[ST_MUL1].drho_mag}),
		.product (t1_p)
	);

	cgp_mul t3_mul (
		.clk     (clk),
		.mul_a   (e_q),
		.mul_b   ({30'd0, ctx_s[ST_MUL1].drho_mag}),
		.product (t3_p)
	);

	// ---------------- first subtract: a = dm - u drho, p1 = dm - u drho / 2 ----------------
	always_comb begin
		dm64 = {{32{ctx_s[ST_SUB1].dm[31]}}, ctx_s[ST_SUB1].dm};
		t1s = apply_sign(t1_p, ctx_s[ST_SUB1].m_neg ^ ctx_s[ST_SUB1].drho_neg);
		// half product is the magnitude shifted down, sign kept
		hs = apply_sign({1'b0, t1_p[MAG_W-1:1]},
			ctx_s[ST_SUB1].m_neg ^ ctx_s[ST_SUB1].drho_neg);
		t3s = apply_sign(t3_p, ctx_s[ST_SUB1].en_neg ^ ctx_s[ST_SUB1].drho_neg);
	end

	always_ff @(posedge clk) begin
		a_s53 <= clamp_lim(dm64 - t1s);
		p1_s53 <= clamp_lim(dm64 - hs);
		a_mag_s54 <= mag62(a_s53);
		p1_mag_s54 <= mag62(p1_s53);
		um_s[ST_MUL1+1] <= u_q;
		for (int k = ST_MUL1 + 2; k <= ST_MUL2; k++) begin
			um_s[k] <= um_s[k-1];
		end
		t3_s[ST_SUB1+1] <= t3s;
		for (int k = ST_SUB1 + 2; k <= ST_SUB3; k++) begin
			t3_s[k] <= t3_s[k-1];
		end
	end

	// u * a and u * p1, and the velocity slope a / rho
	cgp_mul t2_mul (
		.clk     (clk),
		.mul_a   (um_s[ST_MUL2]),
		.mul_b   (a_mag_s54),
		.product (t2_p)
	);

	cgp_mul p2_mul (
		.clk     (clk),
		.mul_a   (um_s[ST_MUL2]),
		.mul_b   (p1_mag_s54),
		.product (p2_p)
	);

	cgp_div vs_div (
		.clk      (clk),
		.dividend (a_mag_s54),
		.divisor  (ctx_s[ST_MUL2].rho),
		.quotient (vs_q)
	);

	// ---------------- energy terms ----------------
	always_comb begin
		de64 = {{32{ctx_s[ST_SUB2].de[31]}}, ctx_s[ST_SUB2].de};
		t2s = apply_sign(t2_p, ctx_s[ST_SUB2].m_neg ^ ctx_s[ST_SUB2].a_neg);
		p2s = apply_sign(p2_p, ctx_s[ST_SUB2].m_neg ^ ctx_s[ST_SUB2].p1_neg);
	end

	always_ff @(posedge clk) begin
		ts0_s58 <= clamp_lim(de64 - t2s);
		qv_s58 <= clamp_lim(de64 - p2s);
		ts1_s59 <= clamp_lim(ts0_s58 - t3_s[ST_SUB3]);
		q_mag_s59 <= mag62(qv_s58);
		ts1_mag_s60 <= mag62(ts1_s59);
	end

	// pressure slope scale by gamma minus one
	cgp_mul ps_mul (
		.clk     (clk),
		.mul_a   ({17'd0, gamma_m1_q}),
		.mul_b   (q_mag_s59),
		.product (ps_p)
	);

	// temperature term over rho, then scale by inverse heat capacity
	cgp_div ts_div (
		.clk      (clk),
		.dividend (ts1_mag_s60),
		.divisor  (ctx_s[ST_DIVT].rho),
		.quotient (ts_q)
	);

	cgp_mul tc_mul (
		.clk     (clk),
		.mul_a   ({17'd0, inv_cv_q}),
		.mul_b   ({14'd0, ts_q}),
		.product (tc_p)
	);

	// ---------------- side data pipeline ----------------
	always_comb begin
		for (int k = 1; k < N_STG; k++) begin
			ctx_nxt[k] = ctx_s[k];
		end
		// signs and early results join the side data as they appear
		ctx_nxt[ST_ABS1].a_neg = a_s53[63];
		ctx_nxt[ST_ABS1].p1_neg = p1_s53[63];
		ctx_nxt[ST_SUB3].q_neg = qv_s58[63];
		ctx_nxt[ST_MULG].ts_neg = ts1_s59[63];
		ctx_nxt[ST_PS].ps = sat32(ps_p, ctx_s[ST_PS].q_neg);
		ctx_nxt[ST_VS].vs = sat32({14'd0, vs_q}, ctx_s[ST_VS].a_neg);
	end

	always_ff @(posedge clk) begin
		ctx_s[1] <= ctx_in;
		for (int k = 1; k < N_STG; k++) begin
			ctx_s[k+1] <= ctx_nxt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= N_STG; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[1] <= start && !busy;
			for (int k = 1; k < N_STG; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	// ---------------- output ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[ST_FIN];
		end
	end

	always_ff @(posedge clk) begin
		res_q.last_out <= ctx_s[ST_FIN].last;
		res_q.bad_density <= ctx_s[ST_FIN].bad;
		if (ctx_s[ST_FIN].bad) begin
			// non-positive density gives zero slopes
			res_q.pressure_slope <= '0;
			res_q.velocity_slope <= '0;
			res_q.temperature_slope <= '0;
		end else begin
			res_q.pressure_slope <= ctx_s[ST_FIN].ps;
			res_q.velocity_slope <= ctx_s[ST_FIN].vs;
			res_q.temperature_slope <= sat32(tc_p, ctx_s[ST_FIN].ts_neg);
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

// ----- rtl/cgp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgp_div
// pipelined restoring divider, one quotient bit per stage:
// quotient = floor(dividend * 2^16 / divisor), all ones when it overflows
// ----------------------------------------------------------------------------
module cgp_div import cgp_pkg::*; (
	input  logic             clk,
	input  logic [MAG_W-1:0] dividend,
	input  logic [30:0]      divisor,
	output logic [QUO_W-1:0] quotient
);

	div_stage_t cur [QUO_W];
	div_stage_t nxt [QUO_W];
	div_stage_t stage_s [QUO_W];

	always_comb begin
		logic [31:0] t;
		logic        ge;
		logic [31:0] diff;
		t = '0;
		ge = 1'b0;
		diff = '0;
		// first step sees the upper dividend bits as partial remainder
		cur[0].sat = ({1'b0, dividend[MAG_W-1:32]} >= divisor);
		cur[0].dvs = divisor;
		cur[0].rem = cur[0].sat ? 31'd0 : {1'b0, dividend[MAG_W-1:32]};
		cur[0].bits = {dividend[31:0], 16'd0};
		cur[0].quo = '0;
		for (int k = 1; k < QUO_W; k++) begin
			cur[k] = stage_s[k-1];
		end
		for (int k = 0; k < QUO_W; k++) begin
			t = {cur[k].rem, cur[k].bits[QUO_W-1]};
			ge = (t >= {1'b0, cur[k].dvs});
			diff = t - {1'b0, cur[k].dvs};
			nxt[k].sat = cur[k].sat;
			nxt[k].dvs = cur[k].dvs;
			nxt[k].rem = ge ? diff[30:0] : t[30:0];
			nxt[k].bits = {cur[k].bits[QUO_W-2:0], 1'b0};
			nxt[k].quo = {cur[k].quo[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QUO_W; k++) begin
			stage_s[k] <= nxt[k];
		end
	end

	assign quotient = stage_s[QUO_W-1].sat ? '1 : stage_s[QUO_W-1].quo;

endmodule

// ----- rtl/cgp_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgp_mul
// three stage Q16.16 magnitude multiplier:
// product = min(floor(mul_a * mul_b / 2^16), 2^62-1)
// ----------------------------------------------------------------------------
module cgp_mul import cgp_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] mul_a,
	input  logic [MAG_W-1:0]   mul_b,
	output logic [MAG_W-1:0]   product
);

	logic [55:0]  pp0_s1;
	logic [53:0]  pp1_s1;
	logic [55:0]  pp2_s1;
	logic [53:0]  pp3_s1;
	logic [85:0]  sa_s2;
	logic [85:0]  sb_s2;
	logic [MAG_W-1:0] product_s3;
	logic [109:0] full;

	always_ff @(posedge clk) begin
		// 24 x 32 and 24 x 30 partial products
		pp0_s1 <= 56'(mul_a[23:0]) * 56'(mul_b[31:0]);
		pp1_s1 <= 54'(mul_a[23:0]) * 54'(mul_b[61:32]);
		pp2_s1 <= 56'(mul_a[47:24]) * 56'(mul_b[31:0]);
		pp3_s1 <= 54'(mul_a[47:24]) * 54'(mul_b[61:32]);
		sa_s2 <= 86'(pp0_s1) + {pp1_s1, 32'd0};
		sb_s2 <= 86'(pp2_s1) + {pp3_s1, 32'd0};
		product_s3 <= (|full[109:78]) ? '1 : full[77:16];
	end

	assign full = 110'(sa_s2) + {sb_s2, 24'd0};
	assign product = product_s3;

endmodule

// ----- tb/cgp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgp_checker
// watches the request, result and config channels, predicts the primitive
// slopes of each request and compares them in order with what comes out
// ----------------------------------------------------------------------------
module cgp_checker import cgp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  cgp_in_t              in_item,
	input  logic                 done,
	input  cgp_out_t             result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [30:0]          wr_data,
	output int                   errors,
	output int                   outstanding
);

	localparam logic [127:0] SAT_Q = 128'h3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ONE_HALF = 64'sd32768;

	logic [30:0] gamma_m1;
	logic [30:0] inv_cv;
	cgp_out_t    slopes_due[$];

	// saturate an exact intermediate to the internal range
	function automatic logic signed [63:0] q_clamp(logic signed [65:0] v);
		if (v > $signed({2'b00, SAT_Q[63:0]})) return SAT_Q[63:0];
		if (v < -$signed({2'b00, SAT_Q[63:0]})) return -$signed(SAT_Q[63:0]);
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [65:0] d;
		d = 66'(a) - 66'(b);
		return q_clamp(d);
	endfunction

	// magnitude product truncated by 16 bits, then signed
	function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
		logic [127:0] ma, mb, p;
		logic signed [63:0] r;
		ma = a[63] ? 128'(-a) : 128'(a);
		mb = b[63] ? 128'(-b) : 128'(b);
		p = (ma * mb) >> 16;
		if (p > SAT_Q) p = SAT_Q;
		r = p[63:0];
		return (a[63] != b[63]) ? -r : r;
	endfunction

	// quotient truncated toward zero, divisor positive
	function automatic logic signed [63:0] q_div(logic signed [63:0] a, logic [30:0] d);
		logic [127:0] ma, q;
		logic signed [63:0] r;
		ma = a[63] ? 128'(-a) : 128'(a);
		q = (ma << 16) / 128'(d);
		if (q > SAT_Q) q = SAT_Q;
		r = q[63:0];
		return a[63] ? -r : r;
	endfunction

	function automatic logic signed [31:0] to_q32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic cgp_out_t primitive_slopes(cgp_in_t x);
		cgp_out_t o;
		logic signed [63:0] rho, u, e, drho, dm, de, a, ps, ts;
		o = '0;
		o.last_out = x.last_point;
		rho  = 64'(x.density);
		drho = 64'(x.density_slope);
		dm   = 64'(x.momentum_slope);
		de   = 64'(x.energy_slope);
		if (rho <= 0) begin
			o.bad_density = 1'b1;
			return o;
		end
		u = q_div(64'(x.momentum), rho[30:0]);
		e = q_div(64'(x.total_energy), rho[30:0]);
		a = q_sub(dm, q_mul(u, drho));
		o.velocity_slope = to_q32(q_div(a, rho[30:0]));
		ps = q_sub(dm, q_mul(ONE_HALF, q_mul(u, drho)));
		ps = q_sub(de, q_mul(u, ps));
		o.pressure_slope = to_q32(q_mul(64'(gamma_m1), ps));
		ts = q_sub(de, q_mul(u, a));
		ts = q_sub(ts, q_mul(e, drho));
		ts = q_div(ts, rho[30:0]);
		o.temperature_slope = to_q32(q_mul(64'(inv_cv), ts));
		return o;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h want %h", $time, field, got, want);
		errors++;
	endtask

	assign outstanding = slopes_due.size();

	always @(posedge clk or negedge arst_n) begin
		cgp_out_t want;
		if (!arst_n) begin
			gamma_m1 <= GAMMA_M1_RST;
			inv_cv <= INV_CV_RST;
			errors = 0;
			slopes_due.delete();
		end else begin
			if (wr_en) begin
				if (wr_index == CFG_GAMMA_M1) gamma_m1 <= wr_data;
				else if (wr_index == CFG_INV_CV) inv_cv <= wr_data;
			end
			if (start && !busy) slopes_due.push_back(primitive_slopes(in_item));
			if (done) begin
				if (slopes_due.size() == 0) begin
					report("unexpected result", result.pressure_slope, 32'd0);
				end else begin
					want = slopes_due.pop_front();
					if (result.pressure_slope !== want.pressure_slope)
						report("pressure_slope", result.pressure_slope, want.pressure_slope);
					if (result.velocity_slope !== want.velocity_slope)
						report("velocity_slope", result.velocity_slope, want.velocity_slope);
					if (result.temperature_slope !== want.temperature_slope)
						report("temperature_slope", result.temperature_slope,
							want.temperature_slope);
					if (result.bad_density !== want.bad_density)
						report("bad_density", 32'(result.bad_density), 32'(want.bad_density));
					if (result.last_out !== want.last_out)
						report("last_out", 32'(result.last_out), 32'(want.last_out));
				end
			end
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the conservative to primitive gradient pipeline:
// directed corner points, then bursts of random points across several gamma
// minus one and inverse heat capacity settings, checked by cgp_checker
// ----------------------------------------------------------------------------
module tb import cgp_pkg::*; ();

	// unmapped register indexes, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int PIPE_DRAIN = 200;
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	cgp_in_t              in_item = '0;
	logic                 done;
	cgp_out_t             result;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [30:0]          wr_data = '0;
	int                   errors;
	int                   outstanding;
	int                   cycles = 0;
	int                   burst_left = 0;

	always #2 clk = ~clk;

	conservative_gradient_to_primitive i_dut (
		.clk, .arst_n, .start, .busy, .in_item, .done, .result,
		.wr_en, .wr_index, .wr_data
	);

	cgp_checker i_checker (
		.clk, .arst_n, .start, .busy, .in_item, .done, .result,
		.wr_en, .wr_index, .wr_data, .errors, .outstanding
	);

	// hard stop in case the pipeline hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("conservative_gradient_to_primitive: mismatch");
			$finish;
		end
	end

	// one request, sent in bursts with random idle gaps between them
	task automatic send_point(cgp_in_t x);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		in_item <= x;
		do @(posedge clk); while (busy);
	endtask

	// config only goes in with the pipe empty
	task automatic settle();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// signed q16.16 spread over small, wide and extreme magnitudes
	function automatic logic [31:0] any_q();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = $urandom_range(0, 32'h0010_0000);
				if ($urandom_range(0, 1)) v = -v;
			end
			4, 5, 6: v = $urandom;
			7: v = 32'h7FFF_FFFF;
			8: v = 32'h8000_0000;
			default: v = $urandom_range(0, 3) - 2;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] any_density();
		logic [31:0] mask;
		mask = (32'd1 << $urandom_range(0, 31)) - 1;
		if ($urandom_range(0, 99) < 12) begin
			// non-positive density
			case ($urandom_range(0, 2))
				0: return 32'd0;
				1: return 32'h8000_0000;
				default: return -($urandom & mask & 32'h7FFF_FFFF);
			endcase
		end
		return 32'd1 + ($urandom & mask & 32'h7FFF_FFFE);
	endfunction

	function automatic cgp_in_t any_point();
		cgp_in_t x;
		x.density = any_density();
		x.momentum = any_q();
		x.total_energy = any_q();
		x.density_slope = any_q();
		x.momentum_slope = any_q();
		x.energy_slope = any_q();
		x.last_point = ($urandom_range(0, 7) == 0);
		return x;
	endfunction

	function automatic cgp_in_t point(logic [31:0] r, logic [31:0] m, logic [31:0] en,
			logic [31:0] dr, logic [31:0] dm, logic [31:0] de, logic lp);
		cgp_in_t x;
		x.density = r;
		x.momentum = m;
		x.total_energy = en;
		x.density_slope = dr;
		x.momentum_slope = dm;
		x.energy_slope = de;
		x.last_point = lp;
		return x;
	endfunction

	task automatic random_run(int n);
		repeat (n) send_point(any_point());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners with reset defaults
		send_point(point(32'h0001_0000, 32'h0002_0000, 32'h000A_0000,
			32'h0000_8000, 32'h0001_0000, 32'h0003_0000, 1'b0));
		send_point(point(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd5, 32'd6, 32'd7, 1'b1));
		send_point(point(32'h8000_0000, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0));
		send_point(point(32'hFFFF_FFFF, 32'h1234, 32'h5678, 32'd1, 32'd2, 32'd3, 1'b1));
		// smallest density: quotients blow up and saturate
		send_point(point(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		send_point(point(32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
		send_point(point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		send_point(point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 1'b1));
		send_point(point(32'h0000_0100, 32'hFFFF_0000, 32'h0010_0000, 32'hFFFF_8000,
			32'h0000_4000, 32'hFFF0_0000, 1'b0));
		send_point(point(32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0));
		send_point(point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_point(point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
		send_point(point(32'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
		random_run(160);
		settle();

		// register extremes, spare indexes must not disturb them
		write_reg(CFG_GAMMA_M1, 31'h7FFF_FFFF);
		write_reg(CFG_INV_CV, 31'h7FFF_FFFF);
		write_reg(CFG_SPARE_A, 31'd0);
		write_reg(CFG_SPARE_B, 31'd0);
		wr_en <= 1'b0;
		send_point(point(32'h0001_0000, 32'h0003_0000, 32'h0100_0000,
			32'h0000_1000, 32'h0002_0000, 32'h0040_0000, 1'b0));
		random_run(170);
		settle();

		write_reg(CFG_GAMMA_M1, 31'd0);
		write_reg(CFG_INV_CV, 31'd0);
		wr_en <= 1'b0;
		random_run(150);
		settle();

		// typical air values
		write_reg(CFG_GAMMA_M1, 31'd26214);
		write_reg(CFG_INV_CV, 31'd91);
		wr_en <= 1'b0;
		random_run(200);
		settle();

		write_reg(CFG_GAMMA_M1, 31'($urandom));
		write_reg(CFG_INV_CV, 31'($urandom));
		wr_en <= 1'b0;
		random_run(200);
		settle();

		if (errors == 0) begin
			$display("conservative_gradient_to_primitive: match");
		end else begin
			$display("conservative_gradient_to_primitive: mismatch");
		end
		$finish;
	end

endmodule
